// File: design/sorted_timestamp_binary_search_macros.svh
// Assertion macros shared by the timestamp search block.
`ifndef SORTED_TIMESTAMP_BINARY_SEARCH_MACROS_SVH
`define SORTED_TIMESTAMP_BINARY_SEARCH_MACROS_SVH

// Checked on every clock edge outside reset.
`define STBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define STBS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/stbs_pkg.sv
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TIME_W      = 32;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 10;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // signed search bounds: range -1 .. TABLE_DEPTH
    localparam int SW          = CNT_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic start;   // latch key, open the range, issue first probe
        logic append;  // store time_value at the next free slot
        logic clear;   // empty the table
        logic step;    // narrow the range and issue the next probe
        logic finish;  // load the result register
    } ctrl_t;

    typedef struct packed {
        logic done;      // search has its answer
        logic out_free;  // result register can take a beat
    } stat_t;

    // middle of [a, b], truncated toward zero
    function automatic logic [IDX_W-1:0] mid_of(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
        logic [SW:0] sum;
        sum = {a[SW-1], a} + {b[SW-1], b};
        if (sum[SW])
            return '0;
        else
            return sum[IDX_W:1];
    endfunction

endpackage

// File: design/stbs_ram.sv
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/stbs_datapath.sv
`include "sorted_timestamp_binary_search_macros.svh"

module stbs_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stbs_pkg::ctrl_t              ctrl,
    output stbs_pkg::stat_t              stat,
    input  logic [stbs_pkg::TIME_W-1:0]  time_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [stbs_pkg::POS_W-1:0]   position
);

    localparam int IDX_W = stbs_pkg::IDX_W;
    localparam int CNT_W = stbs_pkg::CNT_W;
    localparam int SW    = stbs_pkg::SW;
    localparam int POS_W = stbs_pkg::POS_W;

    logic [CNT_W-1:0]                count_reg, count_next;
    logic [stbs_pkg::TIME_W-1:0]     key_reg;
    logic signed [SW-1:0]            lo_reg, lo_next;
    logic signed [SW-1:0]            hi_reg, hi_next;
    logic [IDX_W-1:0]                mid_reg, mid_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            found_reg;
    logic [POS_W-1:0]                position_reg;

    logic [IDX_W-1:0]                rd_addr;
    logic [stbs_pkg::TIME_W-1:0]     probe;
    logic                            full;
    logic                            empty;
    logic                            hit;
    logic signed [SW-1:0]            hi_start;
    logic signed [SW-1:0]            mid_s;
    logic [IDX_W+POS_W-1:0]          mid_ext;

    assign full     = (count_reg == CNT_W'(stbs_pkg::TABLE_DEPTH));
    assign empty    = (count_reg == '0);
    assign hit      = !empty && (probe == key_reg);
    assign hi_start = $signed({1'b0, count_reg}) - $signed(SW'(1));
    assign mid_s    = $signed({{(SW-IDX_W){1'b0}}, mid_reg});
    assign mid_ext  = {{POS_W{1'b0}}, mid_reg};

    stbs_ram #(
        .WIDTH (stbs_pkg::TIME_W),
        .DEPTH (stbs_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ctrl.append && !full),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (time_value),
        .rd_addr (rd_addr),
        .rd_data (probe)
    );

    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.append && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctrl.start)
        begin
            lo_next = '0;
            hi_next = hi_start;
        end
        else if (ctrl.step)
        begin
            if (key_reg < probe)
                hi_next = mid_s - $signed(SW'(1));
            else
                lo_next = mid_s + $signed(SW'(1));
        end
        // issue the probe for the range that the next cycle works on
        if (ctrl.start || ctrl.step)
            mid_next = stbs_pkg::mid_of(lo_next, hi_next);
        else
            mid_next = mid_reg;
        rd_addr = mid_next;
    end

    assign stat.done     = empty || hit || (lo_reg >= hi_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (ctrl.start)
        begin
            key_reg <= time_value;
        end
        if (ctrl.finish)
        begin
            found_reg    <= hit;
            position_reg <= hit ? mid_ext[POS_W-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    `STBS_ASSERT_ALWAYS(a_count_bound, (!rst_n || count_reg <= CNT_W'(stbs_pkg::TABLE_DEPTH)), "entry count beyond table depth")
    `STBS_ASSERT(a_probe_inside, (ctrl.step |=> (CNT_W'(mid_reg) < count_reg)), "probe outside the filled part")
    `STBS_ASSERT(a_count_held, (ctrl.step |=> $stable(count_reg)), "table changed during a search")
    `STBS_ASSERT(a_finish_shown, (ctrl.finish |=> out_valid_reg), "finished search gave no beat")
    `STBS_ASSERT(a_no_overwrite, ((out_valid_reg && out_stall) |-> !ctrl.finish), "stalled result overwritten")

endmodule

// File: design/stbs_ctrl.sv
module stbs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [stbs_pkg::CMD_W-1:0]  command,
    input  stbs_pkg::stat_t             stat,
    output stbs_pkg::ctrl_t             ctrl
);

    stbs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= stbs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (command)
                        stbs_pkg::CMD_APPEND: ctrl.append = 1'b1;
                        stbs_pkg::CMD_SEARCH:
                        begin
                            ctrl.start = 1'b1;
                            state_next = stbs_pkg::ST_SEARCH;
                        end
                        stbs_pkg::CMD_CLEAR:  ctrl.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            stbs_pkg::ST_SEARCH:
            begin
                if (stat.done)
                begin
                    // hold the last probe until the result register frees up
                    if (stat.out_free)
                    begin
                        ctrl.finish = 1'b1;
                        state_next  = stbs_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            default: state_next = stbs_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: design/sorted_timestamp_binary_search.sv
// Sorted timestamp table with binary search.
// Input channel: in_valid / in_stall carries one beat of command and time_value.
//   Append stores time_value at the next free slot (dropped when the table is
//   full), clear empties the table, search looks time_value up; the unused
//   command code is taken and ignored. Only a search gives an output beat.
// Output channel: out_valid / out_stall carries found and position (position
//   is zero when found is low). A one-deep result register sits on this side.
// Timing: append and clear never raise in_stall. A search holds in_stall high
//   from the beat after acceptance until it ends and issues one probe per
//   cycle through the single RAM read port, one table read each, up to
//   floor(log2(entries)) + 1 probes (11 for a full table of 1024); the result
//   register is loaded once the last probe's read returns and the register
//   is free, and out_valid rises from it.
// Stalling: while the result register is full and stalled, a finishing search
//   holds its last probe and in_stall stays high; with no search running,
//   appends and clears still go through.
// Reset: rst_n clears the entry count and the output valid; table contents
//   are not cleared, and only slots below the entry count can give a match.
module sorted_timestamp_binary_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [stbs_pkg::CMD_W-1:0]   command,
    input  logic [stbs_pkg::TIME_W-1:0]  time_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         found,
    output logic [stbs_pkg::POS_W-1:0]   position
);

    // command and status between sequencer and datapath
    stbs_pkg::ctrl_t ctrl;
    stbs_pkg::stat_t stat;

    stbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    stbs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .time_value (time_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .position   (position)
    );

endmodule

// File: sim/timestamp_search_checker.sv
module timestamp_search_checker
    import stbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [TIME_W-1:0] time_value,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              found,
    input  logic [POS_W-1:0]  position,
    output int                mismatches,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] slot;
    } answer_t;

    logic [TIME_W-1:0] stamps [TABLE_DEPTH];
    int                entries     = 0;
    int                fault_count = 0;
    answer_t           search_answers [$];

    // Probe sequence of the search: middle truncated toward zero, stop on a hit,
    // give up once the range has closed.
    function automatic answer_t look_up(input logic [TIME_W-1:0] key);
        answer_t           ans;
        int                lo;
        int                hi;
        int                mid;
        bit                searching;
        logic [TIME_W-1:0] probe;
        ans = '0;
        if (entries == 0)
            return ans;
        lo = 0;
        hi = entries - 1;
        searching = 1'b1;
        while (searching)
        begin
            mid = (lo + hi) / 2;
            if (mid < 0 || mid >= entries)
                return ans;
            probe = stamps[mid];
            if (probe == key)
            begin
                ans.hit  = 1'b1;
                ans.slot = mid[POS_W-1:0];
                searching = 1'b0;
            end
            else if (lo >= hi)
                searching = 1'b0;
            else if (key < probe)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            entries = 0;
            search_answers.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                case (command)
                    CMD_APPEND:
                        if (entries < TABLE_DEPTH)
                        begin
                            stamps[entries] = time_value;
                            entries++;
                        end
                    CMD_SEARCH: search_answers = {search_answers, look_up(time_value)};
                    CMD_CLEAR:  entries = 0;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (search_answers.size() == 0)
                begin
                    $display("%0t: result beat with none expected: found %0b position %0d",
                             $time, found, position);
                    fault_count++;
                end
                else
                begin
                    want = search_answers.pop_front();
                    if (found !== want.hit)
                    begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.hit, found);
                        fault_count++;
                    end
                    if (position !== want.slot)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.slot, position);
                        fault_count++;
                    end
                end
            end
        end
        mismatches <= fault_count;
        pending    <= search_answers.size();
    end

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    // Command code that the block takes and ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RUN_ITEMS      = 1450;
    localparam int QUIET_ITEMS    = 150;   // last beats run with no idling
    localparam int FILL_AFTER     = 200;   // beats before the full-table phase
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 30;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  command    = CMD_APPEND;
    logic [TIME_W-1:0] time_value = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              found;
    logic [POS_W-1:0]  position;

    int mismatches;
    int pending;

    int   beats_sent  = 0;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   stall_left  = 0;
    int   stall_cycle = 0;
    int   idle_cycles = 0;
    logic quiet       = 1'b0;
    bit   full_done   = 1'b0;

    // Values the table should hold now; only steers the choice of search keys.
    logic [TIME_W-1:0] stored [$];

    sorted_timestamp_binary_search dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .time_value (time_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .position   (position)
    );

    timestamp_search_checker search_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .time_value (time_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .position   (position),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Present one beat and hold it until the block takes it, then perhaps
    // drop valid for a random burst. Valid stays high straight into the next
    // beat when there is no gap, so it is never lowered and raised in one step.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] value);
        in_valid   <= 1'b1;
        command    <= cmd;
        time_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_APPEND && stored.size() < TABLE_DEPTH)
            stored = {stored, value};
        else if (cmd == CMD_CLEAR)
            stored.delete();
        if (cmd != CMD_UNUSED)
            beats_sent++;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // Append n non-decreasing timestamps; saturate at the top of the range
    // rather than wrap, so the run stays sorted (equal values allowed).
    task automatic append_ascending(input int n, input logic [TIME_W-1:0] start,
                                    input logic [TIME_W-1:0] max_step);
        logic [TIME_W:0] acc;
        acc = {1'b0, start};
        for (int k = 0; k < n; k++)
        begin
            send_beat(CMD_APPEND, acc[TIME_W-1:0]);
            acc = acc + $urandom_range(0, max_step);
            if (acc[TIME_W])
                acc = {1'b0, {TIME_W{1'b1}}};
        end
    endtask

    // Mostly keys that are stored, some one off a stored key, the rest random.
    function automatic logic [TIME_W-1:0] pick_key();
        logic [TIME_W-1:0] key;
        int                roll;
        roll = $urandom_range(0, 99);
        if (stored.size() == 0 || roll >= 85)
            key = $urandom;
        else
        begin
            key = stored[$urandom_range(0, stored.size() - 1)];
            if (roll >= 55)
                key = roll[0] ? key + 1'b1 : key - 1'b1;
        end
        return key;
    endfunction

    // Searches with the odd ignored command mixed in.
    task automatic search_burst(input int m);
        repeat (m)
        begin
            if ($urandom_range(0, 99) < 5)
                send_beat(CMD_UNUSED, $urandom);
            send_beat(CMD_SEARCH, pick_key());
        end
    endtask

    // Result side: stall in random bursts, with the rate re-picked now and
    // then so that calm stretches appear as well.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 200 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 5;
                2:       stall_pct <= 20;
                default: stall_pct <= 50;
            endcase
        end
        if (quiet)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 11);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: empty table, extremes of the timestamp, the ignored
        // command, a single entry, and appends out of order.
        gap_pct = 25;
        send_beat(CMD_SEARCH, 32'h0000_0000);
        send_beat(CMD_SEARCH, 32'hFFFF_FFFF);
        send_beat(CMD_UNUSED, 32'h1234_5678);
        send_beat(CMD_APPEND, 32'h0000_0000);
        send_beat(CMD_APPEND, 32'h0000_0005);
        send_beat(CMD_APPEND, 32'hFFFF_FFFF);
        send_beat(CMD_SEARCH, 32'h0000_0000);
        send_beat(CMD_SEARCH, 32'h0000_0005);
        send_beat(CMD_SEARCH, 32'hFFFF_FFFF);
        send_beat(CMD_SEARCH, 32'h0000_0003);
        send_beat(CMD_SEARCH, 32'h8000_0000);
        send_beat(CMD_CLEAR,  32'h0000_0000);
        send_beat(CMD_SEARCH, 32'h0000_0005);
        send_beat(CMD_APPEND, 32'h0000_0007);
        send_beat(CMD_SEARCH, 32'h0000_0007);
        send_beat(CMD_SEARCH, 32'h0000_0006);
        send_beat(CMD_SEARCH, 32'h0000_0008);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF);
        send_beat(CMD_SEARCH, 32'h0000_0007);
        send_beat(CMD_APPEND, 32'h0000_0009);
        send_beat(CMD_APPEND, 32'h0000_0002);
        send_beat(CMD_SEARCH, 32'h0000_0002);
        send_beat(CMD_SEARCH, 32'h0000_0009);
        send_beat(CMD_CLEAR,  32'hFFFF_FFFF);

        // Random part: mostly a clear, a sorted run of random length and
        // spacing, then searches; the rest piles unsorted appends and noise
        // onto whatever the table holds.
        while (beats_sent < RUN_ITEMS)
        begin
            if (beats_sent >= RUN_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase

            if (!full_done && beats_sent >= FILL_AFTER)
            begin
                // Hold the sender until every answer is back, then fill the
                // table to the brim, push a few appends that must be dropped,
                // and search, the first and last slots included.
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
                send_beat(CMD_CLEAR, $urandom);
                append_ascending(TABLE_DEPTH, $urandom_range(0, 3), 32'd4194299);
                repeat (4)
                    send_beat(CMD_APPEND, $urandom);
                send_beat(CMD_SEARCH, stored[0]);
                send_beat(CMD_SEARCH, stored[TABLE_DEPTH-1]);
                search_burst(40);
                full_done = 1'b1;
            end
            else if ($urandom_range(0, 99) < 80)
            begin
                logic [TIME_W-1:0] start;
                logic [TIME_W-1:0] max_step;
                int                run_len;
                case ($urandom_range(0, 3))
                    0:       start = '0;
                    1:       start = $urandom_range(0, 1000);
                    2:       start = $urandom >> 1;
                    default: start = 32'hFFFF_FF00;
                endcase
                case ($urandom_range(0, 2))
                    0:       max_step = 32'd3;
                    1:       max_step = 32'd65535;
                    default: max_step = 32'h0FFF_FFFF;
                endcase
                run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                      : $urandom_range(0, 12);
                send_beat(CMD_CLEAR, $urandom);
                append_ascending(run_len, start, max_step);
                search_burst($urandom_range(2, 12));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 99) < 15)
                        send_beat(CMD_UNUSED, $urandom);
                    else
                        send_beat(CMD_APPEND, $urandom);
                end
                search_burst($urandom_range(1, 6));
            end
        end

        // Drain: drop valid, wait for the last answers, then let the block
        // settle for a while in case something stray turns up.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
